/* src/rma_pkg.sv */
// Shared types and constants for the rounded moving average unit.
// Command and status words between controller and datapath. No dependencies.
package rma_pkg;

	localparam logic OP_PUSH  = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	localparam int CFG_BITS     = 8;
	localparam int RESET_WINDOW = 8;

	typedef struct packed {
		logic accept;     // input word taken, issue ring read
		logic cfg_write;  // window size write
		logic update;     // ring write and running-sum update
		logic div_start;  // load dividend into the divider
		logic out_load;   // capture quotient into output register
	} rma_cmd_t;

	typedef struct packed {
		logic div_done;
	} rma_status_t;

endpackage

/* src/rma_divider.sv */
// Restoring divider, one quotient bit per cycle.
// Standalone; used by rma_datapath.
module rma_divider #(
	parameter int DW = 24,
	parameter int NW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [NW-1:0] divisor,
	output logic [DW-1:0] quotient,
	output logic          done
);

	localparam int CNTW = (DW > 1) ? $clog2(DW) : 1;

	logic [DW-1:0]   quo_q;
	logic [NW-1:0]   rem_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [NW:0]     trial;
	logic [NW:0]     diff;
	logic            qbit;

	always_comb begin
		trial = {rem_q, quo_q[DW-1]};
		diff  = trial - {1'b0, divisor};
		qbit  = (trial >= {1'b0, divisor});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNTW'(DW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// dividend shifts out of the top of quo_q as quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], qbit};
			rem_q <= qbit ? diff[NW-1:0] : trial[NW-1:0];
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

/* src/rma_datapath.sv */
// Datapath: window register, sample ring memory, pointer, fill count,
// running sum, rounding and output register. Uses rma_pkg and rma_divider.
module rma_datapath
	import rma_pkg::*;
#(
	parameter int MAX_WINDOW  = 128,
	parameter int SAMPLE_BITS = 16,
	parameter int NW          = 8,
	parameter int DW          = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rma_cmd_t               cmd,
	output rma_status_t            status,
	input  logic                   operation,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic [CFG_BITS-1:0]    cfg_data,
	output logic [SAMPLE_BITS-1:0] average
);

	localparam int PW = $clog2(MAX_WINDOW);
	localparam int FW = $clog2(MAX_WINDOW + 1);
	localparam int SW = SAMPLE_BITS + FW;

	logic [SAMPLE_BITS-1:0] mem [MAX_WINDOW];
	logic [SAMPLE_BITS-1:0] rd_q;
	logic [SAMPLE_BITS-1:0] sample_q;
	logic [SAMPLE_BITS-1:0] average_q;
	logic [NW-1:0]          window_q;
	logic [PW-1:0]          ptr_q;
	logic [PW-1:0]          wp_q;
	logic [FW-1:0]          fill_q;
	logic [SW-1:0]          sum_q;

	logic [NW-1:0]          ring_len;
	logic [NW-1:0]          cfg_window;
	logic [NW:0]            ptr_inc;
	logic [PW-1:0]          ptr_next;
	logic                   full;
	logic [SAMPLE_BITS-1:0] old_val;
	logic [DW-1:0]          dividend;
	logic [DW-1:0]          quotient;
	logic                   div_done;

	always_comb begin
		// reset window may exceed the ring depth; the ring then wraps at its depth
		ring_len = (int'(window_q) > MAX_WINDOW) ? NW'(MAX_WINDOW) : window_q;
		if (cfg_data == '0)
			cfg_window = NW'(1);
		else if (int'(cfg_data) > MAX_WINDOW)
			cfg_window = NW'(MAX_WINDOW);
		else
			cfg_window = NW'(cfg_data);
		ptr_inc  = (NW + 1)'(ptr_q) + 1'b1;
		ptr_next = (ptr_inc >= {1'b0, ring_len}) ? '0 : ptr_inc[PW-1:0];
		// slot about to be overwritten holds live data only once the ring is full
		full     = (fill_q == ring_len[FW-1:0]);
		old_val  = full ? rd_q : '0;
		dividend = DW'(sum_q) + DW'(window_q >> 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= NW'(RESET_WINDOW);
			ptr_q    <= '0;
			fill_q   <= '0;
			sum_q    <= '0;
		end else if (cmd.cfg_write) begin
			window_q <= cfg_window;
			ptr_q    <= '0;
			fill_q   <= '0;
			sum_q    <= '0;
		end else if (cmd.accept && operation == OP_CLEAR) begin
			fill_q <= '0;
			sum_q  <= '0;
		end else if (cmd.update) begin
			ptr_q <= wp_q;
			sum_q <= sum_q - SW'(old_val) + SW'(sample_q);
			if (!full)
				fill_q <= fill_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sample_q <= sample;
			wp_q     <= ptr_next;
		end
		if (cmd.out_load)
			average_q <= quotient[SAMPLE_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.update)
			mem[wp_q] <= sample_q;
		if (cmd.accept)
			rd_q <= mem[ptr_next];
	end

	rma_divider #(
		.DW(DW),
		.NW(NW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (window_q),
		.quotient (quotient),
		.done     (div_done)
	);

	assign status.div_done = div_done;
	assign average         = average_q;

endmodule

/* src/rma_ctrl.sv */
// Controller state machine: handshakes and sequencing of ring update and divide.
// Uses rma_pkg for the command and status words.
module rma_ctrl
	import rma_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	output logic        out_valid,
	input  logic        out_stall,
	input  rma_status_t status,
	output rma_cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_DIV_START,
		ST_DIVIDE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	always_comb begin
		out_free      = !out_valid_q || !out_stall;
		in_stall      = (state_q != ST_IDLE);
		cfg_ready     = (state_q == ST_IDLE);
		cmd.accept    = (state_q == ST_IDLE) && in_valid;
		cmd.cfg_write = cfg_valid && cfg_ready;
		cmd.update    = (state_q == ST_UPDATE);
		cmd.div_start = (state_q == ST_DIV_START);
		cmd.out_load  = (state_q == ST_DIVIDE) && status.div_done && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= (operation == OP_CLEAR) ? ST_DIV_START : ST_UPDATE;
				end
				ST_UPDATE:    state_q <= ST_DIV_START;
				ST_DIV_START: state_q <= ST_DIVIDE;
				ST_DIVIDE: begin
					if (cmd.out_load)
						state_q <= ST_IDLE;
				end
				default:      state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* src/rounded_moving_average_unit.sv */
// Rounded boxcar moving average over the last window_size samples, held in a
// ring memory with a running sum. Each input word pushes a sample or clears
// the ring; each returns one word, (sum + N/2) / N. One word is in work at a
// time: a push steps through the update, divide-start and divide states, a
// clear skips the update, and the bit-serial divider yields one quotient bit
// per cycle. A finished word waits in the output register while the next
// input word is taken. A fill count marks which ring slots are live, so reset,
// clear and window writes take effect at once with no clearing pass. Write the
// window size only while the unit is idle.
module rounded_moving_average_unit
	import rma_pkg::*;
#(
	parameter int MAX_WINDOW  = 128,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   operation,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [SAMPLE_BITS-1:0] average,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_BITS-1:0]    cfg_data
);

	localparam int NMAX = (MAX_WINDOW > RESET_WINDOW) ? MAX_WINDOW : RESET_WINDOW;
	localparam int NW   = $clog2(NMAX + 1);
	localparam int DW   = SAMPLE_BITS + NW;

	rma_cmd_t    cmd;
	rma_status_t status;

	rma_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	rma_datapath #(
		.MAX_WINDOW  (MAX_WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS),
		.NW          (NW),
		.DW          (DW)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.operation (operation),
		.sample    (sample),
		.cfg_data  (cfg_data),
		.average   (average)
	);

`ifndef SYNTHESIS
	// an accepted word keeps the input stalled while its update and divide states run
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall ##1 in_stall)
		else $error("input taken again too early");

	// window writes are only taken while no word is in work
	a_cfg_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready |-> !in_stall)
		else $error("config ready while busy");

	// a new result only appears at the end of a word's work
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without work in progress");
`endif

endmodule

/* tb/rounded_moving_average_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the rounded moving average unit: mirrors the sample ring, write
// pointer and running sum, predicts every average word and compares it.
// Depends on rma_pkg.
module rounded_moving_average_checker
	import rma_pkg::*;
#(
	parameter int MAX_WINDOW  = 128,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_stall,
	input  logic                   operation,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic                   out_valid,
	input  logic                   out_stall,
	input  logic [SAMPLE_BITS-1:0] average,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [CFG_BITS-1:0]    cfg_data,
	output int                     mismatches,
	output int                     pending,
	output int                     checked
);
	localparam int PTR_BITS   = $clog2(MAX_WINDOW);
	localparam int SUM_BITS   = SAMPLE_BITS + PTR_BITS;

	logic [SAMPLE_BITS-1:0] ring [MAX_WINDOW];
	logic [PTR_BITS-1:0]    wr_ptr;
	logic [SUM_BITS-1:0]    win_sum;
	logic [PTR_BITS:0]      window_len;
	logic [31:0]            quotient;
	logic [SAMPLE_BITS-1:0] want;
	logic [SAMPLE_BITS-1:0] avg_expected_q [$];

	task automatic empty_ring();
		foreach (ring[i])
			ring[i] = '0;
		win_sum = '0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_ring();
			wr_ptr     = '0;
			window_len = (PTR_BITS + 1)'(RESET_WINDOW);
			avg_expected_q.delete();
			mismatches <= 0;
			pending    <= 0;
			checked    <= 0;
		end else begin
			// window write clamps to 1..MAX_WINDOW and starts from an empty ring
			if (cfg_valid && cfg_ready) begin
				if (cfg_data == '0)
					window_len = (PTR_BITS + 1)'(1);
				else if (cfg_data > MAX_WINDOW)
					window_len = (PTR_BITS + 1)'(MAX_WINDOW);
				else
					window_len = (PTR_BITS + 1)'(cfg_data);
				empty_ring();
				wr_ptr = '0;
			end

			if (in_valid && !in_stall) begin
				if (operation == OP_CLEAR) begin
					empty_ring();
				end else begin
					// pointer moves first, then the slot is overwritten
					if (int'(wr_ptr) + 1 >= int'(window_len))
						wr_ptr = '0;
					else
						wr_ptr = wr_ptr + 1'b1;
					win_sum = win_sum - SUM_BITS'(ring[wr_ptr]) + SUM_BITS'(sample);
					ring[wr_ptr] = sample;
				end
				quotient = (32'(win_sum) + 32'(window_len >> 1)) / 32'(window_len);
				avg_expected_q.push_back(quotient[SAMPLE_BITS-1:0]);
			end

			if (out_valid && !out_stall) begin
				if (avg_expected_q.size() == 0) begin
					mismatches <= mismatches + 1;
					$display("%0t: average mismatch, expected none, actual %0d",
						$time, average);
				end else begin
					want = avg_expected_q.pop_front();
					checked <= checked + 1;
					if (average !== want) begin
						mismatches <= mismatches + 1;
						$display("%0t: average mismatch, expected %0d, actual %0d",
							$time, want, average);
					end
				end
			end

			pending <= avg_expected_q.size();
		end
	end

endmodule

/* tb/rounded_moving_average_unit_tb.sv */
`timescale 1ns / 1ps
// Top of the moving average testbench: clock, reset, stimulus, receiver stalls,
// watchdog and verdict. Depends on rma_pkg, the unit and the checker module.
module rounded_moving_average_unit_tb;
	import rma_pkg::*;

	localparam int MAX_WINDOW      = 128;
	localparam int SAMPLE_BITS     = 16;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int DRAIN_CYCLES    = 40;
	localparam int PHASES          = 9;
	localparam int RANDOM_SIZE     = -1;

	// window per phase (0 and 255 exercise the clamp), and words per phase
	localparam int PHASE_WINDOW [PHASES] = '{3, 128, 1, 17, 255, 2, 0, RANDOM_SIZE, 8};
	localparam int PHASE_WORDS  [PHASES] = '{120, 300, 80, 150, 200, 100, 60, 200, 140};

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	logic                   operation;
	logic [SAMPLE_BITS-1:0] sample;
	logic                   out_valid;
	logic                   out_stall;
	logic [SAMPLE_BITS-1:0] average;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_BITS-1:0]    cfg_data;

	logic rx_gaps_on;
	logic hold_off_tgl;
	bit   tx_gaps_on;
	int   mismatches;
	int   pending;
	int   checked;
	int   quiet_cycles;
	int   words_sent;
	int   clears_sent;
	int   cfg_writes;

	rounded_moving_average_unit #(
		.MAX_WINDOW (MAX_WINDOW),
		.SAMPLE_BITS(SAMPLE_BITS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.operation(operation),
		.sample   (sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.average  (average),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	rounded_moving_average_checker #(
		.MAX_WINDOW (MAX_WINDOW),
		.SAMPLE_BITS(SAMPLE_BITS)
	) avg_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.sample    (sample),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.average   (average),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.mismatches(mismatches),
		.pending   (pending),
		.checked   (checked)
	);

	always #5 clk = ~clk;

	// called at a rising edge; returns at the edge where the word was taken
	// or after the idle gap that follows it
	task automatic send_word(input logic op, input logic [SAMPLE_BITS-1:0] smp);
		in_valid  <= 1'b1;
		operation <= op;
		sample    <= smp;
		do @(posedge clk); while (in_stall);
		words_sent++;
		if (op == OP_CLEAR)
			clears_sent++;
		if (tx_gaps_on && $urandom_range(0, 99) < 34) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < 34);
		end
	endtask

	task automatic wait_drained();
		if (in_valid)
			in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_window(input logic [CFG_BITS-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cfg_writes++;
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int hold_left;
		logic seen_tgl;
		hold_left = 0;
		seen_tgl  = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_tgl !== seen_tgl) begin
				seen_tgl  = hold_off_tgl;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= rx_gaps_on && ($urandom_range(0, 99) < 34);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
		    (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no handshake for %0d cycles, %0d words outstanding",
				$time, quiet_cycles, pending);
			$display("end of test: mismatches");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int win;
		logic op;
		logic [SAMPLE_BITS-1:0] smp;

		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		operation    <= OP_PUSH;
		sample       <= '0;
		cfg_valid    <= 1'b0;
		cfg_data     <= '0;
		rx_gaps_on   <= 1'b1;
		hold_off_tgl <= 1'b0;
		tx_gaps_on   = 1'b1;
		words_sent   = 0;
		clears_sent  = 0;
		cfg_writes   = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset window of 8: extremes, alternating bits, clear with junk sample
		send_word(OP_PUSH, '1);
		send_word(OP_PUSH, '0);
		send_word(OP_PUSH, 16'd1);
		send_word(OP_PUSH, 16'hAAAA);
		send_word(OP_PUSH, 16'h5555);
		send_word(OP_CLEAR, '1);
		send_word(OP_PUSH, '1);

		// zero is taken as a window of one
		wait_drained();
		write_window('0);
		send_word(OP_PUSH, '1);
		send_word(OP_PUSH, 16'd7);
		send_word(OP_CLEAR, '0);

		// above the maximum is taken as the maximum
		wait_drained();
		write_window('1);
		send_word(OP_PUSH, '1);
		send_word(OP_PUSH, 16'd1);

		// window of two: rounding of odd sums
		wait_drained();
		write_window(CFG_BITS'(2));
		send_word(OP_PUSH, 16'd1);
		send_word(OP_PUSH, 16'd0);
		send_word(OP_PUSH, 16'd3);
		send_word(OP_PUSH, '1);

		wait_drained();
		write_window(CFG_BITS'(MAX_WINDOW));
		send_word(OP_PUSH, '1);

		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			win = (PHASE_WINDOW[p] == RANDOM_SIZE) ? $urandom_range(1, MAX_WINDOW)
			                                       : PHASE_WINDOW[p];
			write_window(CFG_BITS'(win));
			// one long stretch with no idling on either side
			tx_gaps_on = (p != 3);
			rx_gaps_on <= (p != 3);
			for (int i = 0; i < PHASE_WORDS[p]; i++) begin
				if (p == 4 && i == 40)
					hold_off_tgl <= ~hold_off_tgl;
				if (p == 5 && i == 50)
					wait_drained();
				if (p == 4 && i < 130) begin
					// full-scale run drives the running sum to its maximum
					op  = OP_PUSH;
					smp = '1;
				end else begin
					op = ($urandom_range(0, 99) < 6) ? OP_CLEAR : OP_PUSH;
					case ($urandom_range(0, 9))
						0:       smp = '0;
						1:       smp = '1;
						2:       smp = SAMPLE_BITS'($urandom_range(0, 3));
						default: smp = SAMPLE_BITS'($urandom);
					endcase
				end
				send_word(op, smp);
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d words (%0d clears) over %0d window writes, sizes 1 to %0d",
			words_sent, clears_sent, cfg_writes, MAX_WINDOW);
		$display("%0d average words checked, %0d mismatches", checked, mismatches);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
